// File: rtl/core/assert_macros.svh
// Assertion macros shared by the RTL, compiled out for synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Clocked assertion on clk, held off while rst_n is low.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Clocked assertion on clk that is also checked during reset.
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_CLK(label, prop, msg)
`define ASSERT_ALWAYS(label, prop, msg)
`endif
`endif

// File: rtl/core/mmf_pkg.sv
// Package with the widths, defaults and reset values of the moving median filter.
`timescale 1ns / 1ps
package mmf_pkg;
    localparam int WS_W               = 7;
    localparam int MAX_WINDOW_DEF     = 64;
    localparam int SAMPLE_WIDTH_DEF   = 16;
    localparam logic [WS_W-1:0] WS_RESET = 7'd5;

    typedef logic [WS_W-1:0] win_size_t;
endpackage

// File: rtl/core/moving_median_filter.sv
// Top level of the moving median filter: history, order matrix and median select.
`timescale 1ns / 1ps
`include "assert_macros.svh"
// Moving median filter.
// Input channel: sample with sample_valid / sample_stall. A beat moves at a rising
// edge where sample_valid is high and sample_stall is low. Output channel: median
// with median_valid / median_stall, same rule. Every input beat gives one output beat.
// The configuration port writes window_size whenever cfg_wr_en is high; it is meant
// to be written only while no beat is in flight. Zero acts as one, values above
// MAX_WINDOW act as MAX_WINDOW.
// The accepting edge shifts the sample into the history and updates a pairwise
// order matrix with one row of comparators against the new sample; the median is
// then loaded into the output register on an edge where the pipeline advances. The matrix rank
// count, the rank match and the middle-pair add sit between those two registers.
// Throughput is one beat per cycle. A stalled output holds the whole pipeline, so
// sample_stall is high whenever a finished result waits under median_stall.
// Reset (rst_n low, asynchronous) clears the history to zeros, sets the order
// matrix to match an all-zero history, empties the pipeline and sets window_size
// to five.
module moving_median_filter #(
    parameter int MAX_WINDOW   = mmf_pkg::MAX_WINDOW_DEF,
    parameter int SAMPLE_WIDTH = mmf_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_wr_en,
    input  mmf_pkg::win_size_t             cfg_wr_data,
    input  logic                           sample_valid,
    output logic                           sample_stall,
    input  logic signed [SAMPLE_WIDTH-1:0] sample,
    output logic                           median_valid,
    input  logic                           median_stall,
    output logic signed [SAMPLE_WIDTH-1:0] median
);
    import mmf_pkg::*;

    localparam int CNT_W = $clog2(MAX_WINDOW + 1);
    localparam int CMP_W = (CNT_W > WS_W) ? CNT_W : WS_W;
    localparam logic [CMP_W-1:0] MAX_N = CMP_W'(MAX_WINDOW);

    // Sample history, newest at index zero.
    logic signed [SAMPLE_WIDTH-1:0] win_reg [MAX_WINDOW];
    // Order matrix: ord_reg[i][j] is set when entry j sorts ahead of entry i.
    // Equal values are ordered by age, the newer one first.
    logic [MAX_WINDOW-1:0] ord_reg [MAX_WINDOW];
    win_size_t ws_reg;
    logic      stage_valid_reg;
    logic      out_valid_reg;
    logic signed [SAMPLE_WIDTH-1:0] median_reg;

    logic advance;
    logic accept;
    logic [CMP_W-1:0] ws_ext;
    logic [CMP_W-1:0] n_eff;
    logic [CNT_W-1:0] n_cnt;
    logic [CNT_W-1:0] k_hi;
    logic [CNT_W-1:0] k_lo;
    logic [MAX_WINDOW-1:0] in_win;
    logic [CNT_W-1:0] rank [MAX_WINDOW];
    logic signed [SAMPLE_WIDTH-1:0] mid_hi;
    logic signed [SAMPLE_WIDTH-1:0] mid_lo;
    logic signed [SAMPLE_WIDTH:0]   pair_sum;
    logic signed [SAMPLE_WIDTH-1:0] median_next;

    // The pipeline moves when the output register is empty or being taken.
    assign advance      = !out_valid_reg || !median_stall;
    assign accept       = sample_valid && advance;
    assign sample_stall = !advance;
    assign median_valid = out_valid_reg;
    assign median       = median_reg;

    // Effective window size, clamped to one through MAX_WINDOW.
    always_comb
    begin
        ws_ext = CMP_W'(ws_reg);
        priority if (ws_ext == '0)
        begin
            n_eff = CMP_W'(1);
        end
        else if (ws_ext > MAX_N)
        begin
            n_eff = MAX_N;
        end
        else
        begin
            n_eff = ws_ext;
        end
        n_cnt = n_eff[CNT_W-1:0];
        k_hi  = n_cnt >> 1;
        k_lo  = k_hi - CNT_W'(1);
    end

    // Rank of every entry inside the window, then pick the middle entries.
    always_comb
    begin
        for (int j = 0; j < MAX_WINDOW; j++)
        begin
            in_win[j] = (CNT_W'(j) < n_cnt);
        end
        mid_hi = '0;
        mid_lo = '0;
        for (int i = 0; i < MAX_WINDOW; i++)
        begin
            rank[i] = CNT_W'($countones(ord_reg[i] & in_win));
            if (in_win[i] && (rank[i] == k_hi))
            begin
                mid_hi = mid_hi | win_reg[i];
            end
            if (in_win[i] && (rank[i] == k_lo))
            begin
                mid_lo = mid_lo | win_reg[i];
            end
        end
        pair_sum = (SAMPLE_WIDTH + 1)'(mid_hi) + (SAMPLE_WIDTH + 1)'(mid_lo);
        if (n_cnt[0])
        begin
            median_next = mid_hi;
        end
        else
        begin
            median_next = pair_sum[SAMPLE_WIDTH:1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ws_reg <= WS_RESET;
        end
        else if (cfg_wr_en)
        begin
            ws_reg <= cfg_wr_data;
        end
    end

    // History and order matrix shift together on every accepted beat.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_WINDOW; i++)
            begin
                win_reg[i] <= '0;
                for (int j = 0; j < MAX_WINDOW; j++)
                begin
                    ord_reg[i][j] <= (j < i);
                end
            end
        end
        else if (accept)
        begin
            win_reg[0]    <= sample;
            ord_reg[0][0] <= 1'b0;
            for (int i = 1; i < MAX_WINDOW; i++)
            begin
                win_reg[i]    <= win_reg[i-1];
                ord_reg[0][i] <= (win_reg[i-1] < sample);
                ord_reg[i][0] <= (sample <= win_reg[i-1]);
                for (int j = 1; j < MAX_WINDOW; j++)
                begin
                    ord_reg[i][j] <= ord_reg[i-1][j-1];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else if (advance)
        begin
            stage_valid_reg <= sample_valid;
            out_valid_reg   <= stage_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && stage_valid_reg)
        begin
            median_reg <= median_next;
        end
    end

    `ASSERT_CLK(a_hold_when_full, (out_valid_reg && median_stall) |-> sample_stall,
        "input taken while a result is stalled")
    `ASSERT_CLK(a_accept_fills, accept |=> stage_valid_reg,
        "accepted beat did not reach the order stage")
    `ASSERT_CLK(a_stage_to_out, (stage_valid_reg && advance) |=> out_valid_reg,
        "beat lost between order stage and output register")
    `ASSERT_CLK(a_size_range, (n_eff != '0) && (n_eff <= MAX_N),
        "effective window size out of range")
endmodule
